### rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms. Compiled out when ASSERT_OFF is set.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

### rtl/lmd_pkg.sv
// ---------------------------------------------------------------------------
// lmd_pkg
// Types, sizes and register codes for the label map dilation block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lmd_pkg;

  localparam int MAX_WIDTH   = 256;
  localparam int MAX_HEIGHT  = 256;
  localparam int COORD_W     = 8;   // column and row counters
  localparam int SIZE_W      = 9;   // map size registers
  localparam int LABEL_W     = 8;
  localparam int CFG_ADDR_W  = 1;

  localparam int QUEUE_DEPTH = 4;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int LEVEL_W     = $clog2(QUEUE_DEPTH + 1);

  localparam logic [SIZE_W-1:0] MIN_SIZE      = SIZE_W'(3);
  localparam logic [SIZE_W-1:0] WIDTH_RESET   = SIZE_W'(133);
  localparam logic [SIZE_W-1:0] HEIGHT_RESET  = SIZE_W'(88);
  localparam logic [SIZE_W-1:0] MAX_WIDTH_SZ  = SIZE_W'(MAX_WIDTH);
  localparam logic [SIZE_W-1:0] MAX_HEIGHT_SZ = SIZE_W'(MAX_HEIGHT);

  localparam logic [CFG_ADDR_W-1:0] REG_MAP_WIDTH  = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] REG_MAP_HEIGHT = CFG_ADDR_W'(1);

  // One queued item: up to two results (pixel above, then the pixel itself)
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;          // row of the input pixel
    logic [LABEL_W-1:0] up_label;
    logic               up_grew;
    logic [LABEL_W-1:0] self_label;
    logic               has_up;
    logic               has_self;
    logic               frame_end;
    logic               frame_grew;
  } item_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               empty;
  } q_stat_t;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] top);
    logic [SIZE_W-1:0] r;
    if (v < MIN_SIZE) r = MIN_SIZE;
    else if (v > top) r = top;
    else r = v;
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/label_map_dilation.sv
// ---------------------------------------------------------------------------
// label_map_dilation
// One streaming pass of four-neighbour region-growing dilation on a label map.
// ---------------------------------------------------------------------------
//  channel  | dir | payload                                   | request
//  ---------+-----+-------------------------------------------+---------------
//  in_      | in  | tdata[7:0] pixel_label                    | 1 input pixel
//  out_     | out | tdata x,y,label; tlast run_end;           | 1 result
//           |     | tuser grew,frame_end,frame_grew           |
//  cfg_     | in  | addr 0 map_width, 1 map_height            | 1 reg write
//
//  One pixel per clock is taken while the queue has room; the row above
//  produces one result per pixel. On the last row each pixel produces two
//  results, so there the single output register, not the input, sets the rate.
//  Results pass the line store read, neighbour select into the queue and the
//  output register, in that order.
//  Reset (synchronous, rst_n low) restores 133 x 88 and clears position;
//  line stores are not cleared. A register write restarts the frame.
//  A stalled output fills the four-entry queue; in_tready drops before it is full.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module label_map_dilation (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // configuration
  input  wire logic                           cfg_we,
  input  wire logic [lmd_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [lmd_pkg::SIZE_W-1:0]     cfg_wdata,
  // pixel stream
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [7:0]                     in_tdata,   // [7:0] pixel_label
  // result stream
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [23:0]                         out_tdata,  // [7:0] out_x, [15:8] out_y,
                                                          // [23:16] out_label
  output logic                                out_tlast,  // run_end
  output logic [2:0]                          out_tuser   // [0] grew, [1] frame_end,
                                                          // [2] frame_grew
);

  logic             push, pop;
  lmd_pkg::item_t   push_item, head;
  lmd_pkg::q_stat_t q_stat;

  // Front: raster position, line stores, neighbour selection
  lmd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_label  (in_tdata),
    .q_stat    (q_stat),
    .push      (push),
    .push_item (push_item)
  );

  // Decoupling queue, one entry per pixel with results
  lmd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  // Back: one or two results per entry, registered output
  lmd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .q_stat     (q_stat),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  // Frame end is always the closing result of its pixel
  `ASSERT_IMPLIES(a_frame_end_last, clk, rst_n, out_tvalid && out_tuser[1], out_tlast)
  // The frame growth flag is only carried with frame end
  `ASSERT_IMPLIES(a_frame_grew_end, clk, rst_n, out_tvalid && out_tuser[2], out_tuser[1])
  // Credit scheme never overfills the queue
  `ASSERT_IMPLIES(a_queue_bound, clk, rst_n, 1'b1,
                  q_stat.level <= lmd_pkg::LEVEL_W'(lmd_pkg::QUEUE_DEPTH))
  // A full queue never receives a push
  `ASSERT_IMPLIES(a_no_push_full, clk, rst_n,
                  q_stat.level == lmd_pkg::LEVEL_W'(lmd_pkg::QUEUE_DEPTH), !push)

endmodule

`default_nettype wire

### rtl/lmd_front.sv
// ---------------------------------------------------------------------------
// lmd_front
// Raster counters, line stores and four-neighbour selection; pushes items.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lmd_front (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_we,
  input  wire logic [lmd_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  wire logic [lmd_pkg::SIZE_W-1:0]         cfg_wdata,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [lmd_pkg::LABEL_W-1:0]        in_label,
  input  wire lmd_pkg::q_stat_t                   q_stat,
  output logic                                    push,
  output lmd_pkg::item_t                          push_item
);

  localparam int CW = lmd_pkg::COORD_W;
  localparam int SW = lmd_pkg::SIZE_W;
  localparam int LW = lmd_pkg::LABEL_W;

  logic [SW-1:0] w_cfg_r, h_cfg_r;
  logic [SW-1:0] w_eff, h_eff;
  logic [CW-1:0] col_r, row_r;
  logic          any_grew_r;

  logic [LW-1:0] upper_mem  [lmd_pkg::MAX_WIDTH];
  logic [LW-1:0] middle_mem [lmd_pkg::MAX_WIDTH];
  logic [LW-1:0] north_rd_r, centre_rd_r, east_rd_r;
  logic [LW-1:0] west_r;

  logic          s1_valid_r;
  logic [CW-1:0] s1_x_r, s1_y_r;
  logic [LW-1:0] s1_lab_r;
  logic          s1_interior_r, s1_has_up_r, s1_has_self_r, s1_last_r;
  logic          s1_west_ok_r, s1_east_ok_r;

  logic          accept, x_end, y_end, interior;
  logic [CW-1:0] east_addr;
  logic [LW-1:0] west, east, up_res;
  logic          up_grew;

  assign w_eff = lmd_pkg::clamp_size(w_cfg_r, lmd_pkg::MAX_WIDTH_SZ);
  assign h_eff = lmd_pkg::clamp_size(h_cfg_r, lmd_pkg::MAX_HEIGHT_SZ);

  // Room for this item even if the one in flight also lands in the queue;
  // nothing is taken while in reset
  assign in_tready = rst_n &&
                     ((SW'(q_stat.level) + SW'(s1_valid_r)) < SW'(lmd_pkg::QUEUE_DEPTH));
  assign accept    = in_tvalid && in_tready;

  assign x_end     = (SW'(col_r) + SW'(1)) == w_eff;
  assign y_end     = (SW'(row_r) + SW'(1)) == h_eff;
  assign interior  = (col_r != '0) && ((SW'(col_r) + SW'(2)) <= w_eff)
                     && (row_r >= CW'(2));
  assign east_addr = col_r + CW'(1);

  // Configuration and raster position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_cfg_r    <= lmd_pkg::WIDTH_RESET;
      h_cfg_r    <= lmd_pkg::HEIGHT_RESET;
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
      if (cfg_we) begin
        unique case (cfg_addr)
          lmd_pkg::REG_MAP_WIDTH:  w_cfg_r <= cfg_wdata;
          lmd_pkg::REG_MAP_HEIGHT: h_cfg_r <= cfg_wdata;
          default: ;
        endcase
        col_r <= '0;
        row_r <= '0;
      end else if (accept) begin
        if (x_end) begin
          col_r <= '0;
          row_r <= y_end ? '0 : row_r + CW'(1);
        end else begin
          col_r <= col_r + CW'(1);
        end
      end
    end
  end

  // Line stores: reads issued on accept, shifted-up centre written in the following cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      north_rd_r        <= upper_mem[col_r];
      centre_rd_r       <= middle_mem[col_r];
      east_rd_r         <= middle_mem[east_addr];
      middle_mem[col_r] <= in_label;
    end
    if (s1_valid_r) begin
      upper_mem[s1_x_r] <= centre_rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_x_r        <= col_r;
      s1_y_r        <= row_r;
      s1_lab_r      <= in_label;
      s1_interior_r <= interior;
      s1_has_up_r   <= row_r != '0;
      s1_has_self_r <= y_end;
      s1_last_r     <= x_end && y_end;
      s1_west_ok_r  <= col_r != '0;
      s1_east_ok_r  <= col_r != CW'(lmd_pkg::MAX_WIDTH - 1);
    end
    if (s1_valid_r) begin
      west_r <= centre_rd_r;
    end
  end

  assign west = s1_west_ok_r ? west_r : '0;
  assign east = s1_east_ok_r ? east_rd_r : '0;

  always_comb begin
    up_res = centre_rd_r;
    if (s1_interior_r && (centre_rd_r == '0)) begin
      priority if (north_rd_r != '0) up_res = north_rd_r;
      else if (west != '0)           up_res = west;
      else if (east != '0)           up_res = east;
      else                           up_res = s1_lab_r;
    end
  end

  assign up_grew = s1_has_up_r && s1_interior_r && (centre_rd_r == '0) && (up_res != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      any_grew_r <= 1'b0;
    end else if (cfg_we) begin
      any_grew_r <= 1'b0;
    end else if (s1_valid_r) begin
      any_grew_r <= s1_last_r ? 1'b0 : (any_grew_r || up_grew);
    end
  end

  assign push = s1_valid_r && (s1_has_up_r || s1_has_self_r);

  always_comb begin
    push_item            = '0;
    push_item.x          = s1_x_r;
    push_item.y          = s1_y_r;
    push_item.up_label   = up_res;
    push_item.up_grew    = up_grew;
    push_item.self_label = s1_lab_r;
    push_item.has_up     = s1_has_up_r;
    push_item.has_self   = s1_has_self_r;
    push_item.frame_end  = s1_last_r;
    push_item.frame_grew = s1_last_r && (any_grew_r || up_grew);
  end

endmodule

`default_nettype wire

### rtl/lmd_queue.sv
// ---------------------------------------------------------------------------
// lmd_queue
// Short item queue between the neighbourhood front and the result back end.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lmd_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire lmd_pkg::item_t push_item,
  input  wire logic           pop,
  output lmd_pkg::item_t      head,
  output lmd_pkg::q_stat_t    q_stat
);

  lmd_pkg::item_t                  slots_r [lmd_pkg::QUEUE_DEPTH];
  logic [lmd_pkg::PTR_W-1:0]       wr_ptr_r, rd_ptr_r;
  logic [lmd_pkg::LEVEL_W-1:0]     level_r;
  logic                            do_pop;

  assign do_pop = pop && (level_r != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      if (push)   wr_ptr_r <= wr_ptr_r + lmd_pkg::PTR_W'(1);
      if (do_pop) rd_ptr_r <= rd_ptr_r + lmd_pkg::PTR_W'(1);
      unique case ({push, do_pop})
        2'b10:   level_r <= level_r + lmd_pkg::LEVEL_W'(1);
        2'b01:   level_r <= level_r - lmd_pkg::LEVEL_W'(1);
        default: level_r <= level_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots_r[wr_ptr_r] <= push_item;
  end

  assign head         = slots_r[rd_ptr_r];
  assign q_stat.level = level_r;
  assign q_stat.empty = level_r == '0;

endmodule

`default_nettype wire

### rtl/lmd_back.sv
// ---------------------------------------------------------------------------
// lmd_back
// Splits each queued item into its results and holds the output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lmd_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire lmd_pkg::item_t   head,
  input  wire lmd_pkg::q_stat_t q_stat,
  output logic                  pop,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic [23:0]           out_tdata,
  output logic                  out_tlast,
  output logic [2:0]            out_tuser
);

  localparam int CW = lmd_pkg::COORD_W;
  localparam int LW = lmd_pkg::LABEL_W;

  logic          out_valid_r;
  logic [CW-1:0] out_x_r, out_y_r;
  logic [LW-1:0] out_label_r;
  logic          grew_r, run_end_r, frame_end_r, frame_grew_r;
  logic          phase_r;   // pixel-above result of the head already sent
  logic          load, emit_up;

  assign load    = (!out_valid_r || out_tready) && !q_stat.empty;
  assign emit_up = head.has_up && !phase_r;
  assign pop     = load && !(emit_up && head.has_self);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      phase_r     <= 1'b0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        phase_r     <= emit_up && head.has_self;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_x_r <= head.x;
      if (emit_up) begin
        out_y_r      <= head.y - CW'(1);
        out_label_r  <= head.up_label;
        grew_r       <= head.up_grew;
        run_end_r    <= !head.has_self;
        frame_end_r  <= 1'b0;
        frame_grew_r <= 1'b0;
      end else begin
        out_y_r      <= head.y;
        out_label_r  <= head.self_label;
        grew_r       <= 1'b0;
        run_end_r    <= 1'b1;
        frame_end_r  <= head.frame_end;
        frame_grew_r <= head.frame_grew;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_label_r, out_y_r, out_x_r};
  assign out_tlast  = run_end_r;
  assign out_tuser  = {frame_grew_r, frame_end_r, grew_r};

endmodule

`default_nettype wire

### tb/label_map_dilation_tb.sv
// ---------------------------------------------------------------------------
// label_map_dilation_tb
// Self-checking bench for the label map dilation block. Label maps of many
// sizes are streamed in raster order under random source gaps and sink
// stalls; a tracker rebuilds the dilated map from the accepted pixels and
// matches every result request, field by field, in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module label_map_dilation_tb;
  import lmd_pkg::*;

  // One expected result, in the field order of out_tdata / out_tuser
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [LABEL_W-1:0] label;
    logic               grew;
    logic               run_end;
    logic               frame_end;
    logic               frame_grew;
  } pixel_result_t;

  // Tracks the map position and both line stores, and queues the dilated
  // pixels that each accepted input pixel releases.
  class dilated_map_tracker;
    logic [LABEL_W-1:0] upper_row [MAX_WIDTH];
    logic [LABEL_W-1:0] middle_row [MAX_WIDTH];
    logic [SIZE_W-1:0]  width_reg;
    logic [SIZE_W-1:0]  height_reg;
    int                 col;
    int                 row;
    bit                 grown;
    pixel_result_t      due[$];
    int                 mismatches;

    function new();
      foreach (upper_row[i]) begin
        upper_row[i]  = '0;
        middle_row[i] = '0;
      end
      width_reg  = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      col        = 0;
      row        = 0;
      grown      = 0;
      mismatches = 0;
    endfunction

    function int clip(logic [SIZE_W-1:0] v, int top);
      if (v < 3) return 3;
      if (v > top) return top;
      return v;
    endfunction

    function int frame_pixels();
      return clip(width_reg, MAX_WIDTH) * clip(height_reg, MAX_HEIGHT);
    endfunction

    // Any register write restarts the frame; line stores keep their contents
    function void write_reg(logic [CFG_ADDR_W-1:0] addr, logic [SIZE_W-1:0] data);
      case (addr)
        REG_MAP_WIDTH:  width_reg  = data;
        REG_MAP_HEIGHT: height_reg = data;
        default: ;
      endcase
      col   = 0;
      row   = 0;
      grown = 0;
    endfunction

    function void take_pixel(logic [LABEL_W-1:0] lab);
      int                 w;
      int                 h;
      int                 x;
      int                 y;
      int                 cnt;
      bit                 interior;
      bit                 is_last;
      logic [LABEL_W-1:0] north;
      logic [LABEL_W-1:0] centre;
      logic [LABEL_W-1:0] east;
      logic [LABEL_W-1:0] west;
      pixel_result_t      r [2];

      w   = clip(width_reg, MAX_WIDTH);
      h   = clip(height_reg, MAX_HEIGHT);
      x   = (col >= w) ? w - 1 : col;
      y   = (row >= h) ? h - 1 : row;
      cnt = 0;

      north  = upper_row[x];
      centre = middle_row[x];
      east   = (x + 1 < MAX_WIDTH) ? middle_row[x + 1] : '0;
      upper_row[x]  = centre;
      middle_row[x] = lab;
      // column to the left was already shifted up, so it holds the row above
      west = (x > 0) ? upper_row[x - 1] : '0;

      if (y >= 1) begin
        r[0]       = '0;
        r[0].x     = COORD_W'(x);
        r[0].y     = COORD_W'(y - 1);
        r[0].label = centre;
        interior   = x >= 1 && x + 2 <= w && y - 1 >= 1 && y + 1 <= h;
        if (interior && centre == '0) begin
          if (north != '0)     r[0].label = north;
          else if (west != '0) r[0].label = west;
          else if (east != '0) r[0].label = east;
          else                 r[0].label = lab;
          r[0].grew = r[0].label != '0;
        end
        if (r[0].grew) grown = 1;
        cnt = 1;
      end
      // bottom row goes out straight away, behind the pixel above it
      if (y + 1 == h) begin
        r[cnt]       = '0;
        r[cnt].x     = COORD_W'(x);
        r[cnt].y     = COORD_W'(y);
        r[cnt].label = lab;
        cnt++;
      end

      is_last = (x + 1 == w) && (y + 1 == h);
      if (cnt > 0) begin
        r[cnt - 1].run_end = 1'b1;
        if (is_last) begin
          r[cnt - 1].frame_end  = 1'b1;
          r[cnt - 1].frame_grew = grown;
        end
      end
      for (int i = 0; i < cnt; i++) due.push_back(r[i]);

      if (is_last) begin
        col   = 0;
        row   = 0;
        grown = 0;
      end else if (x + 1 == w) begin
        col = 0;
        row = y + 1;
      end else begin
        col = x + 1;
        row = y;
      end
    endfunction

    function void match_result(logic [23:0] data, logic tlast, logic [2:0] user);
      pixel_result_t got;
      pixel_result_t want;

      got.x          = data[7:0];
      got.y          = data[15:8];
      got.label      = data[23:16];
      got.run_end    = tlast;
      got.grew       = user[0];
      got.frame_end  = user[1];
      got.frame_grew = user[2];

      if (due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result x=%0d y=%0d label=%0d", $realtime,
                   got.x, got.y, got.label);
        return;
      end
      want = due.pop_front();
      if (got.x !== want.x || got.y !== want.y || got.label !== want.label ||
          got.grew !== want.grew || got.run_end !== want.run_end ||
          got.frame_end !== want.frame_end || got.frame_grew !== want.frame_grew) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result mismatch exp x=%0d y=%0d lab=%0d g=%0b re=%0b fe=%0b fg=%0b",
                   $realtime, want.x, want.y, want.label, want.grew, want.run_end,
                   want.frame_end, want.frame_grew,
                   "\n             got x=%0d y=%0d lab=%0d g=%0b re=%0b fe=%0b fg=%0b",
                   got.x, got.y, got.label, got.grew, got.run_end,
                   got.frame_end, got.frame_grew);
      end
    endfunction
  endclass

  // DUT connections
  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [SIZE_W-1:0]     cfg_wdata;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [7:0]            in_tdata;   // [7:0] pixel_label
  logic                  out_tvalid;
  logic                  out_tready;
  logic [23:0]           out_tdata;  // [7:0] x, [15:8] y, [23:16] label
  logic                  out_tlast;  // run_end
  logic [2:0]            out_tuser;  // [0] grew, [1] frame_end, [2] frame_grew

  dilated_map_tracker map_track;

  int sent;          // accepted pixel requests
  int burst_left;    // pixels left in the current source burst
  int sink_mode;     // current sink stall pattern
  int sink_left;     // cycles until the sink pattern changes

  // Hand-built 10 x 3 map: row 1 walks through keep, north, west, east,
  // south and no-neighbour cases; labels 0 and 255 both appear.
  logic [7:0] crafted_map [30] = '{
    8'd0,   8'd7, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255,
    8'd0,   8'd0, 8'd9, 8'd0, 8'd0, 8'd5, 8'd0, 8'd0, 8'd0, 8'd0,
    8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd3, 8'd0, 8'd0
  };

  label_map_dilation u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  // 2 ns clock
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Sink: switches at random between stall patterns - always
  // ready, coin flip, mostly ready, and long stalls that back the queue up.
  always @(negedge clk) begin
    if (sink_left == 0) begin
      sink_mode = $urandom_range(0, 3);
      sink_left = $urandom_range(20, 200);
    end else begin
      sink_left = sink_left - 1;
    end
    case (sink_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= ($urandom_range(0, 1) == 1);
      2:       out_tready <= ($urandom_range(0, 7) != 0);
      default: out_tready <= ($urandom_range(0, 15) == 0);
    endcase
  end

  // Result monitor, sampled on the rising edge
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      map_track.match_result(out_tdata, out_tlast, out_tuser);
  end

  // Mostly unclaimed pixels so that zeros have claimed neighbours to take
  function automatic logic [7:0] pick_label();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return 8'd0;
    if (r == 6) return 8'd255;
    return 8'($urandom_range(1, 255));
  endfunction

  // Mostly small maps; now and then a size below the floor
  function automatic int pick_small_size();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 2);
    return $urandom_range(3, 12);
  endfunction

  // One pixel request. Entered and left on a falling edge; a burst that
  // runs out is followed by a random gap (sometimes none).
  task automatic send_pixel(input logic [7:0] lab);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 48);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= lab;
    do @(posedge clk); while (!in_tready);
    map_track.take_pixel(lab);
    sent++;
    burst_left--;
    @(negedge clk);
  endtask

  task automatic feed_pixels(input int count);
    repeat (count) send_pixel(pick_label());
  endtask

  // Wait until every expected result is out, then allow for first-row
  // pixels still inside the three-stage pipe
  task automatic drain();
    in_tvalid <= 1'b0;
    while (map_track.due.size() > 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic set_reg(input logic [CFG_ADDR_W-1:0] addr, input int value);
    drain();
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= SIZE_W'(value);
    map_track.write_reg(addr, SIZE_W'(value));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Main sequence
  initial begin
    int mode;
    int area;
    int count;

    map_track  = new();
    sent       = 0;
    burst_left = 0;
    sink_mode  = 0;
    sink_left  = 0;
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_addr   = '0;
    cfg_wdata  = '0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    out_tready = 1'b0;

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: 10 x 3, height written below the floor so it clamps to 3
    set_reg(REG_MAP_WIDTH, 10);
    set_reg(REG_MAP_HEIGHT, 1);
    foreach (crafted_map[i]) send_pixel(crafted_map[i]);

    // Widest map (all size bits set, clamps to 256): two rows and a bit
    // of the bottom row, enough to reach the top column numbers
    set_reg(REG_MAP_WIDTH, 511);
    set_reg(REG_MAP_HEIGHT, 3);
    feed_pixels(2 * MAX_WIDTH + 8);

    // Tallest map on a narrow strip: run past row 128
    set_reg(REG_MAP_WIDTH, 2);
    set_reg(REG_MAP_HEIGHT, 300);
    feed_pixels(3 * 130);

    // Small maps: whole frames, sometimes a trailing partial frame, and
    // sometimes no register write so the stream carries on mid-frame
    while (sent < 1250) begin
      mode = $urandom_range(0, 3);
      if (mode == 0 || mode == 2) set_reg(REG_MAP_WIDTH, pick_small_size());
      if (mode == 1 || mode == 2) set_reg(REG_MAP_HEIGHT, pick_small_size());
      area  = map_track.frame_pixels();
      count = area * $urandom_range(1, 2);
      if ($urandom_range(0, 3) == 0) count += $urandom_range(1, area - 1);
      feed_pixels(count);
    end

    in_tvalid <= 1'b0;
    while (map_track.due.size() > 0) @(negedge clk);
    repeat (12) @(negedge clk);

    if (map_track.mismatches == 0 && map_track.due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run
  initial begin
    #1000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
